// ===== rtl/neighbor_periodic_timer_bank_assert.svh =====
// ----------------------------------------------------------------------------
// Neighbor periodic timer bank: assertion macros
// Concurrent assertion wrappers; defining ASSERT_OFF compiles them out.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_PERIODIC_TIMER_BANK_ASSERT_SVH
`define NEIGHBOR_PERIODIC_TIMER_BANK_ASSERT_SVH

`ifndef ASSERT_OFF

// Checked on every rising edge outside reset.
`define NPTB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define NPTB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define NPTB_ASSERT(label, clk, rst, prop, msg)
`define NPTB_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== rtl/nptb_pkg.sv =====
// ----------------------------------------------------------------------------
// Neighbor periodic timer bank: package
// Constants, codes and the sequencer state type.
// ----------------------------------------------------------------------------
package nptb_pkg;

  localparam logic [19:0] USEC_PER_SEC    = 20'd1000000;
  localparam logic [19:0] USEC_MAX        = 20'd999999;
  localparam logic [19:0] NO_TIMEOUT_SEC  = 20'd1000000;
  localparam logic [15:0] REMAIN_SEC_MAX  = 16'hFFFF;
  localparam logic [7:0]  MISS_MAX        = 8'hFF;
  localparam int          MASK_BITS       = 8;

  // register index, taken from paddr[2]
  localparam logic REG_INTERVAL = 1'b0;
  localparam logic REG_MASK     = 1'b1;

  localparam logic FUNC_START  = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  localparam logic KIND_REPORT  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_NORM  = 5'b00100,
    S_EMIT  = 5'b01000,
    S_SUM   = 5'b10000
  } state_t;

endpackage

// ===== rtl/neighbor_periodic_timer_bank.sv =====
// ----------------------------------------------------------------------------
// Neighbor periodic timer bank
// Per-neighbor periodic timers with expiry reports and a minimum-timeout
// summary, walked entry by entry by a small sequencer.
// ----------------------------------------------------------------------------
// An item is walked over the NUM_NEIGHBORS timer entries one entry at a
// time through a single elapsed/remaining-time datapath: a start item, or a
// neighbor that is not connected, takes only the elapsed check for an entry;
// a connected neighbor adds a second step (remaining-time normalize or expiry
// report), and a report waits while out_stall holds it. A summary ends the
// item, after which the block returns to idle and is ready again, so no new
// item is taken before the last one is through.
// in_stall is high for the whole walk. Only neighbors 0 to 7 can be
// connected.
`include "neighbor_periodic_timer_bank_assert.svh"

module neighbor_periodic_timer_bank
  import nptb_pkg::*;
#(
  parameter int NUM_NEIGHBORS = 8
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [31:0] now_sec,
  input  logic [19:0] now_usec,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [2:0]  neighbor_index,
  output logic [7:0]  miss_total,
  output logic [19:0] timeout_sec,
  output logic [19:0] timeout_usec,
  output logic        none_connected,
  output logic        last
);

  localparam int IDX_W = (NUM_NEIGHBORS > 1) ? $clog2(NUM_NEIGHBORS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_NEIGHBORS - 1);

  // configuration
  logic [15:0] interval_sec;
  logic [7:0]  connected_mask;

  // timer entries; every connected entry gets a fresh remaining time on each
  // item, so it only feeds the running minimum
  logic [31:0] start_sec   [NUM_NEIGHBORS];
  logic [19:0] start_usec  [NUM_NEIGHBORS];
  logic [7:0]  miss_cnt    [NUM_NEIGHBORS];

  // sequencer and item
  state_t          state;
  logic [IDX_W-1:0] idx;
  logic            item_func;
  logic [31:0]     item_sec;
  logic [19:0]     item_usec;
  logic [15:0]     elapsed_lo;

  // running minimum
  logic            best_found;
  logic [15:0]     best_sec;
  logic [19:0]     best_usec;

  logic [IDX_W+2:0] idx_ext;
  logic             conn;
  logic             in_xfer;
  logic             out_free;
  logic [31:0]      elapsed;
  logic             expired;
  logic [15:0]      diff_sec;
  logic signed [20:0] usec_diff;
  logic signed [20:0] usec_one;
  logic signed [17:0] norm_sec;
  logic signed [20:0] norm_usec;
  logic [15:0]      clamp_sec;
  logic [19:0]      clamp_usec;
  logic [7:0]       miss_next;
  logic             wr_restart;
  logic             wr_norm;
  logic             advance;
  logic             cand_valid;
  logic [15:0]      cand_sec;
  logic [19:0]      cand_usec;
  logic             cand_better;

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MASK) ? {24'd0, connected_mask} : {16'd0, interval_sec};

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_sec   <= 16'd1;
      connected_mask <= 8'd0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_INTERVAL: interval_sec   <= pwdata[15:0];
        REG_MASK:     connected_mask <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // entry datapath
  assign idx_ext  = (IDX_W + 3)'(idx);
  assign conn     = (idx_ext < (IDX_W + 3)'(MASK_BITS)) && connected_mask[idx_ext[2:0]];
  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign elapsed  = item_sec - start_sec[idx];
  assign expired  = (elapsed >= {16'd0, interval_sec});

  assign diff_sec  = interval_sec - elapsed_lo;
  assign usec_one  = signed'({1'b0, USEC_PER_SEC});
  assign usec_diff = signed'({1'b0, start_usec[idx]}) - signed'({1'b0, item_usec});

  always_comb begin
    if (usec_diff < -usec_one) begin
      norm_sec  = signed'({2'b00, diff_sec}) - 18'sd2;
      norm_usec = usec_diff + usec_one + usec_one;
    end else if (usec_diff < 21'sd0) begin
      norm_sec  = signed'({2'b00, diff_sec}) - 18'sd1;
      norm_usec = usec_diff + usec_one;
    end else if (usec_diff >= usec_one) begin
      norm_sec  = signed'({2'b00, diff_sec}) + 18'sd1;
      norm_usec = usec_diff - usec_one;
    end else begin
      norm_sec  = signed'({2'b00, diff_sec});
      norm_usec = usec_diff;
    end
  end

  always_comb begin
    if (norm_sec < 18'sd0) begin
      clamp_sec  = 16'd0;
      clamp_usec = 20'd0;
    end else if (norm_sec > signed'({2'b00, REMAIN_SEC_MAX})) begin
      clamp_sec  = REMAIN_SEC_MAX;
      clamp_usec = USEC_MAX;
    end else begin
      clamp_sec  = norm_sec[15:0];
      clamp_usec = norm_usec[19:0];
    end
  end

  assign miss_next = (miss_cnt[idx] == MISS_MAX) ? MISS_MAX : miss_cnt[idx] + 8'd1;

  assign wr_restart = (state == S_CHECK && item_func == FUNC_START) ||
                      (state == S_EMIT && out_free);
  assign wr_norm    = (state == S_NORM);
  assign advance    = (state == S_CHECK && (item_func == FUNC_START || !conn)) ||
                      wr_norm || (state == S_EMIT && out_free);

  always_comb begin
    cand_valid = 1'b0;
    cand_sec   = interval_sec;
    cand_usec  = 20'd0;
    if (wr_restart) begin
      cand_valid = conn;
    end else if (wr_norm) begin
      cand_valid = 1'b1;
      cand_sec   = clamp_sec;
      cand_usec  = clamp_usec;
    end
  end

  assign cand_better = !best_found || (cand_sec < best_sec) ||
                       (cand_sec == best_sec && cand_usec < best_usec);

  // entry store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_NEIGHBORS; i++) begin
        start_sec[i]   <= 32'd0;
        start_usec[i]  <= 20'd0;
        miss_cnt[i]    <= 8'd0;
      end
    end else if (wr_restart) begin
      start_sec[idx]   <= item_sec;
      start_usec[idx]  <= item_usec;
      miss_cnt[idx]    <= (item_func == FUNC_START) ? 8'd0 : miss_next;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      best_found <= 1'b0;
    end else begin
      if (cand_valid && cand_better) begin
        best_found <= 1'b1;
        best_sec   <= cand_sec;
        best_usec  <= cand_usec;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state      <= S_CHECK;
            idx        <= '0;
            best_found <= 1'b0;
          end
        end
        S_CHECK: begin
          elapsed_lo <= elapsed[15:0];
          if (item_func == FUNC_UPDATE && conn) begin
            state <= expired ? S_EMIT : S_NORM;
          end
        end
        S_NORM, S_EMIT: ;
        S_SUM: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (advance) begin
        if (idx == IDX_LAST) begin
          state <= S_SUM;
        end else begin
          idx   <= idx + 1'b1;
          state <= S_CHECK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_func <= func;
      item_sec  <= now_sec;
      item_usec <= now_usec;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_EMIT || state == S_SUM) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      kind           <= KIND_REPORT;
      neighbor_index <= idx_ext[2:0];
      miss_total     <= miss_next;
      timeout_sec    <= 20'd0;
      timeout_usec   <= 20'd0;
      none_connected <= 1'b0;
      last           <= 1'b0;
    end else if (state == S_SUM && out_free) begin
      kind           <= KIND_SUMMARY;
      neighbor_index <= 3'd0;
      miss_total     <= 8'd0;
      timeout_sec    <= best_found ? {4'd0, best_sec} : NO_TIMEOUT_SEC;
      timeout_usec   <= best_found ? best_usec : 20'd0;
      none_connected <= !best_found;
      last           <= 1'b1;
    end
  end

  // assertions
  `NPTB_ASSERT(a_accept_starts_walk, clk, rst,
    in_xfer |=> (state == S_CHECK && idx == '0), "walk did not start at entry 0")
  `NPTB_ASSERT(a_report_miss_nonzero, clk, rst,
    (out_valid && kind == KIND_REPORT) |-> (miss_total != 8'd0 && !last), "bad expiry report")
  `NPTB_ASSERT(a_summary_none, clk, rst,
    (out_valid && last && none_connected) |->
      (timeout_sec == NO_TIMEOUT_SEC && timeout_usec == 20'd0), "bad empty summary")
  `NPTB_ASSERT(a_summary_normalized, clk, rst,
    (out_valid && last && !none_connected) |->
      (timeout_usec < USEC_PER_SEC && timeout_sec <= {4'd0, REMAIN_SEC_MAX}),
    "summary timeout not normalized")

endmodule

// ===== tb/neighbor_periodic_timer_bank_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Neighbor periodic timer bank testbench
// Drives start and update items through a gap-inserting driver, stalls the
// result side at random and checks every result transfer against a local
// model of the timer bank. The model tracks start times, remaining times and
// miss counters for each neighbor. The run goes from the reset settings
// through directed cases to randomized timer phases.
// ----------------------------------------------------------------------------
module neighbor_periodic_timer_bank_tb;
  import nptb_pkg::*;

  localparam int     NB_COUNT   = 8;
  localparam int     IDLE_LIMIT = 2000;
  localparam longint USEC       = longint'(USEC_PER_SEC);
  localparam longint REMAIN_TOP = longint'(REMAIN_SEC_MAX) * USEC + longint'(USEC_MAX);

  typedef struct packed {
    logic        func;
    logic [31:0] sec;
    logic [19:0] usec;
  } timer_item_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  index;
    logic [7:0]  miss;
    logic [19:0] tsec;
    logic [19:0] tusec;
    logic        none;
    logic        last;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        func = 1'b0;
  logic [31:0] now_sec = '0;
  logic [19:0] now_usec = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic [2:0]  neighbor_index;
  logic [7:0]  miss_total;
  logic [19:0] timeout_sec;
  logic [19:0] timeout_usec;
  logic        none_connected;
  logic        last;

  // model state
  logic [15:0] cfg_interval = 16'd1;
  logic [7:0]  cfg_mask = 8'd0;
  logic [31:0] base_sec  [NB_COUNT];
  logic [19:0] base_usec [NB_COUNT];
  logic [15:0] left_sec  [NB_COUNT];
  logic [19:0] left_usec [NB_COUNT];
  logic [7:0]  miss_cnt  [NB_COUNT];

  timer_item_t   pending_items[$];
  timer_result_t expected_results[$];

  int error_count = 0;
  int idle_cycles = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit calm = 1'b0;
  logic in_took = 1'b0;
  logic out_took = 1'b0;

  neighbor_periodic_timer_bank #(
    .NUM_NEIGHBORS(NB_COUNT)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .now_sec(now_sec),
    .now_usec(now_usec),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .neighbor_index(neighbor_index),
    .miss_total(miss_total),
    .timeout_sec(timeout_sec),
    .timeout_usec(timeout_usec),
    .none_connected(none_connected),
    .last(last)
  );

  always #1 clk = ~clk;

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [19:0] draw_usec();
    if ($urandom_range(0, 7) == 0) return 20'($urandom_range(0, 20'hFFFFF));
    return 20'($urandom_range(0, 999999));
  endfunction

  function automatic string fmt_result(input timer_result_t r);
    return $sformatf("kind=%0d idx=%0d miss=%0d tsec=%0d tusec=%0d none=%0d last=%0d",
                     r.kind, r.index, r.miss, r.tsec, r.tusec, r.none, r.last);
  endfunction

  function automatic void flag_error(input string msg);
    if (error_count < 10) $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endfunction

  function automatic void queue_item(input logic f, input logic [31:0] s, input logic [19:0] us);
    timer_item_t it;
    it.func = f;
    it.sec  = s;
    it.usec = us;
    pending_items.push_back(it);
  endfunction

  // walk all timers for one accepted item and queue the results it causes
  function automatic void predict_timers(input logic f, input logic [31:0] ns,
                                         input logic [19:0] nus);
    logic [31:0]   elapsed;
    longint        rem, t, best;
    bit            found;
    timer_result_t r;
    int            i;
    found = 1'b0;
    best  = 0;
    for (i = 0; i < NB_COUNT; i++) begin
      elapsed = ns - base_sec[i];
      if (f == FUNC_START || (cfg_mask[i] && elapsed >= {16'd0, cfg_interval})) begin
        base_sec[i]  = ns;
        base_usec[i] = nus;
        left_sec[i]  = cfg_interval;
        left_usec[i] = '0;
        if (f == FUNC_START) begin
          miss_cnt[i] = '0;
        end else begin
          if (miss_cnt[i] != MISS_MAX) miss_cnt[i]++;
          r = '0;
          r.kind  = KIND_REPORT;
          r.index = 3'(i);
          r.miss  = miss_cnt[i];
          expected_results.push_back(r);
        end
      end else if (cfg_mask[i]) begin
        rem = longint'(cfg_interval) * USEC
              - (longint'(elapsed) * USEC + longint'(nus) - longint'(base_usec[i]));
        if (rem < 0) rem = 0;
        if (rem > REMAIN_TOP) rem = REMAIN_TOP;
        left_sec[i]  = 16'(rem / USEC);
        left_usec[i] = 20'(rem % USEC);
      end
    end
    r = '0;
    r.kind = KIND_SUMMARY;
    r.tsec = NO_TIMEOUT_SEC;
    r.none = 1'b1;
    r.last = 1'b1;
    for (i = 0; i < NB_COUNT; i++) begin
      if (cfg_mask[i]) begin
        t = longint'(left_sec[i]) * USEC + longint'(left_usec[i]);
        if (!found || t < best) begin
          found   = 1'b1;
          best    = t;
          r.tsec  = {4'd0, left_sec[i]};
          r.tusec = left_usec[i];
          r.none  = 1'b0;
        end
      end
    end
    expected_results.push_back(r);
  endfunction

  task automatic apb_write(input logic idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_INTERVAL) cfg_interval = val[15:0];
    else cfg_mask = val[7:0];
  endtask

  // unused upper data bits carry noise
  task automatic write_timers(input logic [15:0] iv, input logic [7:0] mk);
    apb_write(REG_INTERVAL, ($urandom() & 32'hFFFF_0000) | {16'd0, iv});
    apb_write(REG_MASK, ($urandom() & 32'hFFFF_FF00) | {24'd0, mk});
  endtask

  // checked at the rising edge, where the driver's outputs are settled
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  always @(posedge clk) begin
    in_took  <= !rst && in_valid && !in_stall;
    out_took <= !rst && out_valid && !out_stall;
  end

  // input driver: holds a stalled transfer, then inserts a gap per item
  always @(negedge clk) begin
    timer_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else if (!in_valid || in_took) begin
      if (in_valid) in_gap = draw_wait();
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        it = pending_items.pop_front();
        func     <= it.func;
        now_sec  <= it.sec;
        now_usec <= it.usec;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_took) out_gap = draw_wait();
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    timer_result_t got, want;
    if (!rst) begin
      if (in_valid && !in_stall) predict_timers(func, now_sec, now_usec);
      if (out_valid && !out_stall) begin
        got.kind  = kind;
        got.index = neighbor_index;
        got.miss  = miss_total;
        got.tsec  = timeout_sec;
        got.tusec = timeout_usec;
        got.none  = none_connected;
        got.last  = last;
        if (expected_results.size() == 0) begin
          flag_error({"unexpected result ", fmt_result(got)});
        end else begin
          want = expected_results.pop_front();
          if (got !== want)
            flag_error({"expected ", fmt_result(want), " got ", fmt_result(got)});
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int          p, k, i;
    logic [31:0] t;
    logic [15:0] iv;
    logic [7:0]  mk;
    for (i = 0; i < NB_COUNT; i++) begin
      base_sec[i]  = '0;
      base_usec[i] = '0;
      left_sec[i]  = '0;
      left_usec[i] = '0;
      miss_cnt[i]  = '0;
    end
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // reset settings: nothing connected
    queue_item(FUNC_UPDATE, 32'd0, 20'd0);
    queue_item(FUNC_START, 32'd0, 20'd0);
    wait_drained();

    // reset interval, all connected; second update expires every neighbor
    apb_write(REG_MASK, 32'h0000_00FF);
    queue_item(FUNC_UPDATE, 32'd0, 20'd500000);
    queue_item(FUNC_UPDATE, 32'd1, 20'd0);
    wait_drained();

    // widest interval: upper clamp, wrap of the seconds counter, clock going back
    write_timers(REMAIN_SEC_MAX, 8'hFF);
    queue_item(FUNC_START, 32'hFFFF_FFF0, 20'hFFFFF);
    queue_item(FUNC_UPDATE, 32'hFFFF_FFF0, 20'd0);
    queue_item(FUNC_UPDATE, 32'hFFFF_FFF0, 20'd999999);
    queue_item(FUNC_UPDATE, 32'd5, 20'd123456);
    queue_item(FUNC_UPDATE, 32'hFFFF_FF00, 20'd0);
    queue_item(FUNC_UPDATE, 32'hFFFF_FF00 + 32'd65534, 20'd999999);
    queue_item(FUNC_UPDATE, 32'hFFFF_FF00 + 32'd65535, 20'd0);
    wait_drained();

    // lower clamp, then neighbors drifting apart under mask changes
    write_timers(16'd3, 8'h0F);
    queue_item(FUNC_START, 32'd1000, 20'd0);
    queue_item(FUNC_UPDATE, 32'd1002, 20'hFFFFF);
    queue_item(FUNC_UPDATE, 32'd1003, 20'd250000);
    wait_drained();
    apb_write(REG_MASK, 32'h0000_00F0);
    queue_item(FUNC_UPDATE, 32'd1003, 20'd500000);
    wait_drained();
    apb_write(REG_MASK, 32'h0000_00FF);
    queue_item(FUNC_UPDATE, 32'd1004, 20'd0);
    wait_drained();

    // zero interval: every connected neighbor expires on every update
    write_timers(16'd0, 8'h81);
    queue_item(FUNC_UPDATE, 32'd1004, 20'd1);
    queue_item(FUNC_START, 32'd1005, 20'd0);
    wait_drained();

    // long run of expiries drives the miss counters into saturation
    calm = ($urandom_range(0, 1) == 0);
    write_timers(16'd0, 8'($urandom_range(0, 255)) | 8'h01);
    for (k = 0; k < 258; k++) queue_item(FUNC_UPDATE, $urandom(), draw_usec());
    wait_drained();

    // randomized phases: start, then time advancing around the interval
    for (p = 0; p < 6; p++) begin
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0: iv = 16'd1;
        1: iv = REMAIN_SEC_MAX;
        2: iv = 16'd0;
        3: iv = 16'($urandom_range(2, 10));
        default: iv = 16'($urandom_range(1, 65535));
      endcase
      case ($urandom_range(0, 4))
        0: mk = 8'h00;
        1: mk = 8'hFF;
        default: mk = 8'($urandom_range(0, 255));
      endcase
      write_timers(iv, mk);
      t = $urandom();
      queue_item(FUNC_START, t, draw_usec());
      for (k = 0; k < 21; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: t = t + $urandom_range(0, 2 * iv + 1);
          5: t = t + ((iv > 0) ? iv - 1 : 0);
          6: t = t + iv;
          7: ;
          8: t = $urandom();
          default: begin
            queue_item(FUNC_START, t, draw_usec());
            continue;
          end
        endcase
        queue_item(FUNC_UPDATE, t, draw_usec());
      end
      wait_drained();
    end

    repeat (20) @(negedge clk);
    if (expected_results.size() != 0) flag_error("results still outstanding at end");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
